// File: rtl/core/atpr_pkg.sv
// atpr_pkg: shared constants, types and the step-angle table of the tilt unit
// used by atpr_cordic_stage, atpr_cordic and accel_tilt_pitch_roll_unit
// no dependencies
package atpr_pkg;

   localparam int SAMPLE_WIDTH_DEF        = 16;
   localparam int CORDIC_STEPS_DEF        = 16;
   localparam int ANGLE_FRACTION_BITS_DEF = 7;

   localparam int ANGLE_GUARD      = 8;
   localparam int TABLE_FRAC       = 20;
   localparam int TABLE_LEN        = 24;
   localparam int GUARD_SHIFT      = 16;
   localparam int GAIN_FRAC        = 30;
   localparam int HALF_TURN_DEG    = 180;
   localparam int QUARTER_TURN_DEG = 90;
   localparam int PITCH_WIDTH      = 16;
   localparam int ROLL_WIDTH       = 15;

   localparam logic signed [31:0] GAIN_Q30 = 32'sd1768195363;

   // atan(2^-i) in degrees, 20 fraction bits
   localparam longint STEP_DEG_Q20 [TABLE_LEN] = '{
      47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
      234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
      917, 458, 229, 115, 57, 29, 14, 7
   };

   typedef struct packed {
      logic y_zero;
      logic z_neg;
      logic x_zero;
   } flags_type;

   localparam int FLAGS_WIDTH = $bits(flags_type);

   // step angle rounded half up to work_frac fraction bits
   function automatic longint step_angle(input int idx, input int work_frac);
      int     s;
      longint v;
      s = TABLE_FRAC - work_frac;
      v = STEP_DEG_Q20[idx];
      if (s == 0) begin
         return v;
      end
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

endpackage

// File: rtl/core/atpr_cordic_stage.sv
// atpr_cordic_stage: one registered cordic vectoring micro-rotation
// uses atpr_pkg
module atpr_cordic_stage
   import atpr_pkg::*;
#(
   parameter int                       W      = 35,
   parameter int                       ZW     = 25,
   parameter int                       SIDE_W = 1,
   parameter int                       SHIFT  = 0,
   parameter logic signed [ZW-1:0]     ANGLE  = '0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic signed [W-1:0]      in_x,
   input  logic signed [W-1:0]      in_y,
   input  logic signed [ZW-1:0]     in_z,
   input  logic [SIDE_W-1:0]        in_side,
   output logic                     out_valid,
   output logic signed [W-1:0]      out_x,
   output logic signed [W-1:0]      out_y,
   output logic signed [ZW-1:0]     out_z,
   output logic [SIDE_W-1:0]        out_side
);

   logic signed [W-1:0]  dx, dy;
   logic signed [W-1:0]  x_in, y_in;
   logic signed [ZW-1:0] z_in;
   logic                 valid_ff;
   logic signed [W-1:0]  x_ff, y_ff;
   logic signed [ZW-1:0] z_ff;
   logic [SIDE_W-1:0]    side_ff;

   assign dx = in_y >>> SHIFT;
   assign dy = in_x >>> SHIFT;

   always_comb begin
      if (!in_y[W-1]) begin
         x_in = in_x + dx;
         y_in = in_y - dy;
         z_in = in_z + ANGLE;
      end else begin
         x_in = in_x - dx;
         y_in = in_y + dy;
         z_in = in_z - ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      side_ff <= in_side;
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_side  = side_ff;

endmodule

// File: rtl/core/atpr_cordic.sv
// atpr_cordic: pipelined cordic vectoring, half-plane fold stage then one stage per step
// uses atpr_pkg and atpr_cordic_stage
module atpr_cordic
   import atpr_pkg::*;
#(
   parameter int W         = 35,
   parameter int ZW        = 25,
   parameter int STEPS     = CORDIC_STEPS_DEF,
   parameter int WORK_FRAC = ANGLE_FRACTION_BITS_DEF + ANGLE_GUARD,
   parameter int SIDE_W    = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic signed [W-1:0]   in_x,
   input  logic signed [W-1:0]   in_y,
   input  logic [SIDE_W-1:0]     in_side,
   output logic                  out_valid,
   output logic signed [W-1:0]   out_x,
   output logic signed [ZW-1:0]  out_z,
   output logic [SIDE_W-1:0]     out_side
);

   localparam logic signed [ZW-1:0] HALF =
      ZW'(longint'(HALF_TURN_DEG) * (longint'(1) <<< WORK_FRAC));

   logic signed [W-1:0]  x_in, y_in;
   logic signed [ZW-1:0] z_in;

   logic                 valid_pipe [STEPS+1];
   logic signed [W-1:0]  x_pipe     [STEPS+1];
   logic signed [W-1:0]  y_pipe     [STEPS+1];
   logic signed [ZW-1:0] z_pipe     [STEPS+1];
   logic [SIDE_W-1:0]    side_pipe  [STEPS+1];

   // left half plane: rotate by a half turn first
   always_comb begin
      if (in_x[W-1]) begin
         x_in = -in_x;
         y_in = -in_y;
         z_in = in_y[W-1] ? -HALF : HALF;
      end else begin
         x_in = in_x;
         y_in = in_y;
         z_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_pipe[0] <= 1'b0;
      end else begin
         valid_pipe[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      x_pipe[0]    <= x_in;
      y_pipe[0]    <= y_in;
      z_pipe[0]    <= z_in;
      side_pipe[0] <= in_side;
   end

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      atpr_cordic_stage #(
         .W      (W),
         .ZW     (ZW),
         .SIDE_W (SIDE_W),
         .SHIFT  (k),
         .ANGLE  (ZW'(step_angle(k, WORK_FRAC)))
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid_pipe[k]),
         .in_x      (x_pipe[k]),
         .in_y      (y_pipe[k]),
         .in_z      (z_pipe[k]),
         .in_side   (side_pipe[k]),
         .out_valid (valid_pipe[k+1]),
         .out_x     (x_pipe[k+1]),
         .out_y     (y_pipe[k+1]),
         .out_z     (z_pipe[k+1]),
         .out_side  (side_pipe[k+1])
      );
   end

   assign out_valid = valid_pipe[STEPS];
   assign out_x     = x_pipe[STEPS];
   assign out_z     = z_pipe[STEPS];
   assign out_side  = side_pipe[STEPS];

endmodule

// File: rtl/core/accel_tilt_pitch_roll_unit.sv
// accel_tilt_pitch_roll_unit: top level, pitch and roll from one raw accelerometer sample
// uses atpr_pkg and atpr_cordic
//
// usage:
//   raise start with the three raw axis samples on req_accel_first/second/third;
//   the sample is taken on any clock edge with start high and busy low.
//   busy is always low: the pipeline takes one sample every cycle.
//   pitch = atan2(-y, -z), roll = atan2(-x, |(y,z)|), with z = second axis and
//   y = third axis; angles in degrees with ANGLE_FRACTION_BITS fraction bits.
//   each result shows on rsp_pitch_deg/rsp_roll_deg for one cycle with rsp_strobe
//   high, in input order, one per sample.
// pipeline: the input register, the gain multiplier register, two cordic
//   vectoring pipelines of CORDIC_STEPS + 1 stages each and the output register.
// throughput: one sample per cycle.
// reset: synchronous; clears all valid bits, samples in flight are dropped.
// the receiver cannot stall; every result transfer completes in its cycle.
module accel_tilt_pitch_roll_unit
   import atpr_pkg::*;
#(
   parameter int SAMPLE_WIDTH        = SAMPLE_WIDTH_DEF,
   parameter int CORDIC_STEPS        = CORDIC_STEPS_DEF,
   parameter int ANGLE_FRACTION_BITS = ANGLE_FRACTION_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic signed [SAMPLE_WIDTH-1:0] req_accel_first,
   input  logic signed [SAMPLE_WIDTH-1:0] req_accel_second,
   input  logic signed [SAMPLE_WIDTH-1:0] req_accel_third,
   output logic                           rsp_strobe,
   output logic signed [PITCH_WIDTH-1:0]  rsp_pitch_deg,
   output logic signed [ROLL_WIDTH-1:0]   rsp_roll_deg
);

   localparam int SW         = SAMPLE_WIDTH;
   localparam int W          = SW + GUARD_SHIFT + 3;
   localparam int WORK_FRAC  = ANGLE_FRACTION_BITS + ANGLE_GUARD;
   localparam int ZW         = WORK_FRAC + 10;
   localparam int PW         = SW + 33;
   localparam int GAIN_SHIFT = GAIN_FRAC - GUARD_SHIFT;
   localparam int P_SIDE_W   = FLAGS_WIDTH + W;
   localparam int R_SIDE_W   = FLAGS_WIDTH + ZW;

   localparam logic signed [ZW-1:0] HALF =
      ZW'(longint'(HALF_TURN_DEG) * (longint'(1) <<< WORK_FRAC));
   localparam logic signed [ZW-1:0] PITCH_LIM =
      ZW'(longint'(HALF_TURN_DEG) * (longint'(1) <<< ANGLE_FRACTION_BITS));
   localparam logic signed [ZW-1:0] ROLL_LIM =
      ZW'(longint'(QUARTER_TURN_DEG) * (longint'(1) <<< ANGLE_FRACTION_BITS));
   localparam logic signed [ZW-1:0] ROUND_HALF =
      ZW'(longint'(1) <<< (ANGLE_GUARD - 1));
   localparam logic signed [PW-1:0] GAIN_HALF =
      PW'(longint'(1) <<< (GAIN_SHIFT - 1));

   // stage a: negated samples and special-case flags
   logic                 valid_a_ff;
   logic signed [SW:0]   x_neg_a_ff, y_neg_a_ff, z_neg_a_ff;
   flags_type            flags_a_ff;

   // stage b: gain product and guard-scaled pitch vector
   logic                 valid_b_ff;
   logic signed [PW-1:0] prod_b_in, prod_b_ff;
   logic signed [W-1:0]  px_b_in, py_b_in;
   logic signed [W-1:0]  px_b_ff, py_b_ff;
   flags_type            flags_b_ff;

   logic signed [PW-1:0] prod_round;
   logic signed [W-1:0]  ry_b;

   // pitch pipeline
   logic                 p_valid;
   logic signed [W-1:0]  p_mag;
   logic signed [ZW-1:0] p_z;
   logic [P_SIDE_W-1:0]  p_side;
   flags_type            p_flags;
   logic signed [W-1:0]  p_ry;

   // roll pipeline
   logic                 r_valid;
   logic signed [W-1:0]  r_mag;
   logic signed [ZW-1:0] r_z;
   logic [R_SIDE_W-1:0]  r_side;
   flags_type            r_flags;
   logic signed [ZW-1:0] r_pz;

   // output stage
   logic signed [ZW-1:0] pz_sel, rz_sel;
   logic signed [ZW-1:0] pitch_rnd, roll_rnd;
   logic signed [ZW-1:0] pitch_clamp, roll_clamp;
   logic                 strobe_ff;
   logic signed [PITCH_WIDTH-1:0] pitch_ff;
   logic signed [ROLL_WIDTH-1:0]  roll_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else begin
         valid_a_ff <= start & ~busy;
         valid_b_ff <= valid_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      x_neg_a_ff        <= -((SW+1)'(req_accel_first));
      z_neg_a_ff        <= -((SW+1)'(req_accel_second));
      y_neg_a_ff        <= -((SW+1)'(req_accel_third));
      flags_a_ff.y_zero <= (req_accel_third == '0);
      flags_a_ff.z_neg  <= req_accel_second[SW-1];
      flags_a_ff.x_zero <= (req_accel_first == '0);
   end

   assign prod_b_in = x_neg_a_ff * GAIN_Q30;
   assign px_b_in   = W'(z_neg_a_ff) <<< GUARD_SHIFT;
   assign py_b_in   = W'(y_neg_a_ff) <<< GUARD_SHIFT;

   always_ff @(posedge clock) begin
      prod_b_ff  <= prod_b_in;
      px_b_ff    <= px_b_in;
      py_b_ff    <= py_b_in;
      flags_b_ff <= flags_a_ff;
   end

   // gain-scaled -x, rounded half up to the guard scale
   assign prod_round = prod_b_ff + GAIN_HALF;
   assign ry_b       = W'(prod_round >>> GAIN_SHIFT);

   atpr_cordic #(
      .W         (W),
      .ZW        (ZW),
      .STEPS     (CORDIC_STEPS),
      .WORK_FRAC (WORK_FRAC),
      .SIDE_W    (P_SIDE_W)
   ) u_pitch (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid_b_ff),
      .in_x      (px_b_ff),
      .in_y      (py_b_ff),
      .in_side   ({flags_b_ff, ry_b}),
      .out_valid (p_valid),
      .out_x     (p_mag),
      .out_z     (p_z),
      .out_side  (p_side)
   );

   assign p_flags = flags_type'(p_side[P_SIDE_W-1:W]);
   assign p_ry    = p_side[W-1:0];

   atpr_cordic #(
      .W         (W),
      .ZW        (ZW),
      .STEPS     (CORDIC_STEPS),
      .WORK_FRAC (WORK_FRAC),
      .SIDE_W    (R_SIDE_W)
   ) u_roll (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (p_valid),
      .in_x      (p_mag),
      .in_y      (p_ry),
      .in_side   ({p_flags, p_z}),
      .out_valid (r_valid),
      .out_x     (r_mag),
      .out_z     (r_z),
      .out_side  (r_side)
   );

   assign r_flags = flags_type'(r_side[R_SIDE_W-1:ZW]);
   assign r_pz    = r_side[ZW-1:0];

   // y zero: signed-zero atan2 gives 0 or -180; x zero gives roll 0
   always_comb begin
      if (r_flags.y_zero) begin
         pz_sel = r_flags.z_neg ? '0 : -HALF;
      end else begin
         pz_sel = r_pz;
      end
      rz_sel = r_flags.x_zero ? '0 : r_z;
   end

   assign pitch_rnd = (pz_sel + ROUND_HALF) >>> ANGLE_GUARD;
   assign roll_rnd  = (rz_sel + ROUND_HALF) >>> ANGLE_GUARD;

   always_comb begin
      priority if (pitch_rnd > PITCH_LIM) begin
         pitch_clamp = PITCH_LIM;
      end else if (pitch_rnd < -PITCH_LIM) begin
         pitch_clamp = -PITCH_LIM;
      end else begin
         pitch_clamp = pitch_rnd;
      end
      priority if (roll_rnd > ROLL_LIM) begin
         roll_clamp = ROLL_LIM;
      end else if (roll_rnd < -ROLL_LIM) begin
         roll_clamp = -ROLL_LIM;
      end else begin
         roll_clamp = roll_rnd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= r_valid;
      end
   end

   always_ff @(posedge clock) begin
      pitch_ff <= pitch_clamp[PITCH_WIDTH-1:0];
      roll_ff  <= roll_clamp[ROLL_WIDTH-1:0];
   end

   // roll magnitude is not needed past the last stage
   logic unused_mag;
   assign unused_mag = ^r_mag;

   assign rsp_strobe    = strobe_ff;
   assign rsp_pitch_deg = pitch_ff;
   assign rsp_roll_deg  = roll_ff;

endmodule

// File: tb/tb_accel_tilt_pitch_roll_unit.sv
// tb_accel_tilt_pitch_roll_unit: self-checking bench for the accelerometer tilt unit
// sends directed and random sample triples, predicts pitch and roll in a scoreboard
// depends on atpr_pkg and accel_tilt_pitch_roll_unit
module tb_accel_tilt_pitch_roll_unit
   import atpr_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STEPS         = CORDIC_STEPS_DEF;
   localparam int FRAC_BITS     = ANGLE_FRACTION_BITS_DEF;
   localparam int WORK_FRAC     = FRAC_BITS + ANGLE_GUARD;
   localparam int LATENCY       = 2 * STEPS + 5;
   localparam int RANDOM_ITEMS  = 1525;
   localparam int WATCHDOG_MAX  = 1000;

   typedef logic signed [SAMPLE_WIDTH_DEF-1:0] sample_type;
   typedef logic signed [PITCH_WIDTH-1:0]      pitch_type;
   typedef logic signed [ROLL_WIDTH-1:0]       roll_type;

   typedef struct {
      pitch_type pitch;
      roll_type  roll;
   } tilt_angles_type;

   typedef enum int {AXIS_FULL, AXIS_SMALL, AXIS_ZERO, AXIS_EXTREME} axis_kind_type;

   class tilt_scoreboard_type;
      tilt_angles_type pending_angles[$];
      int              samples_taken;
      int              angles_checked;
      int              mismatches;

      function new();
         samples_taken  = 0;
         angles_checked = 0;
         mismatches     = 0;
      endfunction

      function longint vector_angle(inout longint vx, inout longint vy);
         longint acc;
         longint dx;
         longint dy;
         longint step;
         longint half;
         int     s;
         half = longint'(HALF_TURN_DEG) <<< WORK_FRAC;
         s    = TABLE_FRAC - WORK_FRAC;
         acc  = 0;
         if (vx < 0) begin
            acc = (vy >= 0) ? half : -half;
            vx  = -vx;
            vy  = -vy;
         end
         for (int i = 0; i < STEPS && i < TABLE_LEN; i++) begin
            step = STEP_DEG_Q20[i];
            if (s > 0) begin
               step = (step + (longint'(1) <<< (s - 1))) >>> s;
            end
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy >= 0) begin
               vx  += dx;
               vy  -= dy;
               acc += step;
            end else begin
               vx  -= dx;
               vy  += dy;
               acc -= step;
            end
         end
         return acc;
      endfunction

      function longint round_clamp(longint acc, longint limit_deg);
         longint lim;
         longint a;
         lim = limit_deg <<< FRAC_BITS;
         a   = (acc + (longint'(1) <<< (ANGLE_GUARD - 1))) >>> ANGLE_GUARD;
         if (a > lim) begin
            a = lim;
         end
         if (a < -lim) begin
            a = -lim;
         end
         return a;
      endfunction

      function tilt_angles_type tilt_from_sample(sample_type first, sample_type second,
                                                 sample_type third);
         tilt_angles_type res;
         longint          ax;
         longint          az;
         longint          ay;
         longint          px;
         longint          py;
         longint          pz;
         longint          rx;
         longint          ry;
         longint          rz;
         longint          gs;
         longint          pitch_val;
         longint          roll_val;
         ax = longint'(first);
         az = longint'(second);
         ay = longint'(third);
         gs = GAIN_FRAC - GUARD_SHIFT;

         px = -az <<< GUARD_SHIFT;
         py = -ay <<< GUARD_SHIFT;
         pz = vector_angle(px, py);
         if (ay == 0) begin
            pz = (az < 0) ? 0 : -(longint'(HALF_TURN_DEG) <<< WORK_FRAC);
         end

         ry = (-ax * longint'(GAIN_Q30) + (longint'(1) <<< (gs - 1))) >>> gs;
         rx = px;
         rz = vector_angle(rx, ry);
         if (ax == 0) begin
            rz = 0;
         end

         pitch_val = round_clamp(pz, HALF_TURN_DEG);
         roll_val  = round_clamp(rz, QUARTER_TURN_DEG);
         res.pitch = pitch_val[PITCH_WIDTH-1:0];
         res.roll  = roll_val[ROLL_WIDTH-1:0];
         return res;
      endfunction

      function void note_sample(sample_type first, sample_type second, sample_type third);
         pending_angles.insert(pending_angles.size(), tilt_from_sample(first, second, third));
         samples_taken++;
      endfunction

      function void check_angles(pitch_type pitch, roll_type roll);
         tilt_angles_type want;
         if (pending_angles.size() == 0) begin
            $error("unexpected result transfer: pitch_deg %0d, roll_deg %0d", pitch, roll);
            mismatches++;
            return;
         end
         want = pending_angles[0];
         pending_angles.delete(0);
         angles_checked++;
         if (pitch !== want.pitch) begin
            $error("pitch_deg mismatch: expected %0d, actual %0d", want.pitch, pitch);
            mismatches++;
         end
         if (roll !== want.roll) begin
            $error("roll_deg mismatch: expected %0d, actual %0d", want.roll, roll);
            mismatches++;
         end
      endfunction

      function int pending();
         return pending_angles.size();
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   sample_type req_accel_first;
   sample_type req_accel_second;
   sample_type req_accel_third;
   logic       rsp_strobe;
   pitch_type  rsp_pitch_deg;
   roll_type   rsp_roll_deg;

   tilt_scoreboard_type sb;
   logic                sample_taken;
   logic                no_gaps;
   int                  quiet_cycles;

   accel_tilt_pitch_roll_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_accel_first  (req_accel_first),
      .req_accel_second (req_accel_second),
      .req_accel_third  (req_accel_third),
      .rsp_strobe       (rsp_strobe),
      .rsp_pitch_deg    (rsp_pitch_deg),
      .rsp_roll_deg     (rsp_roll_deg)
   );

   initial begin
      clock = 1'b0;
      forever begin
         #2 clock = ~clock;
      end
   end

   always @(posedge clock) begin
      sample_taken = !reset && start && !busy;
      if (!reset) begin
         if (sample_taken) begin
            sb.note_sample(req_accel_first, req_accel_second, req_accel_third);
         end
         if (rsp_strobe) begin
            sb.check_angles(rsp_pitch_deg, rsp_roll_deg);
         end
      end
      if (sample_taken || (!reset && rsp_strobe)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_MAX) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic send_sample(sample_type first, sample_type second, sample_type third);
      while (!no_gaps && $urandom_range(99) < 30) begin
         start            <= 1'b0;
         req_accel_first  <= sample_type'($urandom);
         req_accel_second <= sample_type'($urandom);
         req_accel_third  <= sample_type'($urandom);
         @(negedge clock);
      end
      start            <= 1'b1;
      req_accel_first  <= first;
      req_accel_second <= second;
      req_accel_third  <= third;
      do begin
         @(negedge clock);
      end while (!sample_taken);
   endtask

   function automatic sample_type random_axis(axis_kind_type kind);
      int v;
      case (kind)
         AXIS_SMALL: begin
            v = int'($urandom_range(255)) - 128;
         end
         AXIS_ZERO: begin
            v = 0;
         end
         AXIS_EXTREME: begin
            case ($urandom_range(4))
               0: v = -32768;
               1: v = 32767;
               2: v = -1;
               3: v = 1;
               default: v = 0;
            endcase
         end
         default: begin
            v = int'($urandom);
         end
      endcase
      return sample_type'(v);
   endfunction

   task automatic send_random_sample();
      axis_kind_type kinds[3];
      int            r;
      r = $urandom_range(99);
      for (int a = 0; a < 3; a++) begin
         if (r < 55) begin
            kinds[a] = AXIS_FULL;
         end else if (r < 75) begin
            kinds[a] = AXIS_SMALL;
         end else if (r < 90) begin
            kinds[a] = ($urandom_range(1) == 0) ? AXIS_ZERO : AXIS_FULL;
         end else begin
            kinds[a] = ($urandom_range(2) == 0) ? AXIS_FULL : AXIS_EXTREME;
         end
      end
      send_sample(random_axis(kinds[0]), random_axis(kinds[1]), random_axis(kinds[2]));
   endtask

   initial begin
      sb               = new();
      reset            = 1'b1;
      start            = 1'b0;
      req_accel_first  = '0;
      req_accel_second = '0;
      req_accel_third  = '0;
      sample_taken     = 1'b0;
      no_gaps          = 1'b0;
      quiet_cycles     = 0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // arguments are x, z, y
      send_sample(0, 0, 0);
      send_sample(0, -100, 0);
      send_sample(0, 100, 0);
      send_sample(0, 0, 100);
      send_sample(0, 0, -100);
      send_sample(100, 0, 0);
      send_sample(-100, 0, 0);
      send_sample(-32768, -32768, -32768);
      send_sample(32767, 32767, 32767);
      send_sample(-32768, 32767, -32768);
      send_sample(32767, -32768, 32767);
      send_sample(0, 32767, 1);
      send_sample(0, 32767, -1);
      send_sample(-32768, 0, 1);
      send_sample(32767, 1, 0);
      send_sample(-32768, -1, 0);
      send_sample(1, 1, 1);
      send_sample(-1, -1, -1);
      send_sample(500, -32768, 0);
      send_sample(0, -32768, -32768);
      send_sample(-32768, 1, -1);
      send_sample(32767, -1, 32767);
      send_sample(1234, -5678, 9012);
      send_sample(-20000, 20000, -1);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         no_gaps = (n >= 500 && n < 900);
         send_random_sample();
      end
      start <= 1'b0;

      while (sb.pending() != 0) begin
         @(negedge clock);
      end
      repeat (LATENCY + 8) @(negedge clock);

      $display("tilt unit: %0d samples sent, %0d angle pairs checked, %0d mismatches",
               sb.samples_taken, sb.angles_checked, sb.mismatches);
      $display("stimulus covered axis extremes, zero axes, both half planes and clamping");
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
